@@ src/imusfd_pkg.sv @@
package imusfd_pkg;

   // Frame marker and type bytes of the sensor protocol.
   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_ACCEL  = 8'h51;
   localparam logic [7:0] TYPE_RATE   = 8'h52;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;

   // Frame bytes 1..7 are kept: type byte and three 16-bit axis values.
   localparam int STORED_BYTES = 7;

   // Depth of the queue between the frame collector and the scaler.
   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   // Configuration register map, one 32-bit word per register.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ACCEL_FS = 2'd0,
      REG_RATE_FS  = 2'd1,
      REG_ANGLE_FS = 2'd2
   } reg_index_type;

   localparam logic [4:0]  ACCEL_FS_RESET = 5'd16;
   localparam logic [10:0] RATE_FS_RESET  = 11'd2000;
   localparam logic [7:0]  ANGLE_FS_RESET = 8'd180;

   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2
   } kind_type;

   // Full-scale settings as seen by the scaler.
   typedef struct packed {
      logic [4:0]  accel_fs;
      logic [10:0] rate_fs;
      logic [7:0]  angle_fs;
   } fs_cfg_type;

   // One decoded frame waiting for scaling.
   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } frame_item_type;

   // Result beat; the last member lands in the lowest bits of tdata.
   typedef struct packed {
      logic [1:0]         pad;
      logic signed [27:0] scaled_z;
      logic signed [27:0] scaled_y;
      logic signed [27:0] scaled_x;
      logic signed [15:0] raw_z;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_x;
      logic [1:0]         frame_kind;
   } result_type;

   localparam int RSP_DATA_W = $bits(result_type);

endpackage

@@ src/imusfd_front.sv @@
module imusfd_front
   import imusfd_pkg::*;
#(
   parameter int FRAME_LENGTH = 11
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] rx_byte
   output logic           push,
   output frame_item_type push_item
);

   localparam int POS_W = $clog2(FRAME_LENGTH);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       bytes_ff [STORED_BYTES];
   logic [7:0]       view     [STORED_BYTES];
   logic             accept;
   logic             known;
   kind_type         kind;

   assign accept = req_tvalid && req_tready;

   // Frame position: wait for the header at position zero, wrap after the last byte.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            pos_in = (req_tdata == HEADER_BYTE) ? POS_W'(1) : '0;
         end else if (pos_ff == LAST_POS) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Store frame bytes 1..7; later bytes are only counted.
   always_ff @(posedge clock) begin
      for (int i = 0; i < STORED_BYTES; i++) begin
         if (accept && pos_ff == POS_W'(i + 1)) begin
            bytes_ff[i] <= req_tdata;
         end
      end
   end

   // Frame as it stands including the incoming beat, for short frames
   // whose last byte is also a stored one.
   always_comb begin
      for (int i = 0; i < STORED_BYTES; i++) begin
         view[i] = (pos_ff == POS_W'(i + 1)) ? req_tdata : bytes_ff[i];
      end
   end

   // Classify the frame type.
   always_comb begin
      known = 1'b1;
      kind  = KIND_ACCEL;
      case (view[0])
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_RATE:  kind = KIND_RATE;
         TYPE_ANGLE: kind = KIND_ANGLE;
         default:    known = 1'b0;
      endcase
   end

   // Hand a finished frame of known type to the queue.
   assign push            = accept && (pos_ff == LAST_POS) && known;
   assign push_item.kind  = kind;
   assign push_item.raw_x = {view[2], view[1]};
   assign push_item.raw_y = {view[4], view[3]};
   assign push_item.raw_z = {view[6], view[5]};

endmodule

@@ src/imusfd_queue.sv @@
module imusfd_queue
   import imusfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_item_type push_item,
   input  logic           pop,
   output frame_item_type head_item,
   output logic [1:0]     count
);

   frame_item_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Frame storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ src/imusfd_scale.sv @@
module imusfd_scale
   import imusfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  frame_item_type        head_item,
   input  fs_cfg_type            cfg,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               rsp_valid_ff;
   result_type         rsp_data_ff, rsp_data_in;
   logic [10:0]        fs;
   logic signed [27:0] prod_x, prod_y, prod_z;

   // Take the next frame whenever the output register is free or being drained.
   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   // Full scale of the frame's kind.
   always_comb begin
      case (head_item.kind)
         KIND_ACCEL: fs = 11'(cfg.accel_fs);
         KIND_RATE:  fs = cfg.rate_fs;
         KIND_ANGLE: fs = 11'(cfg.angle_fs);
         default:    fs = '0;
      endcase
   end

   // One multiplier per axis; raw times full scale fits 27 signed bits.
   assign prod_x = 28'(head_item.raw_x * $signed({1'b0, fs}));
   assign prod_y = 28'(head_item.raw_y * $signed({1'b0, fs}));
   assign prod_z = 28'(head_item.raw_z * $signed({1'b0, fs}));

   always_comb begin
      rsp_data_in.pad        = 2'b00;
      rsp_data_in.frame_kind = head_item.kind;
      rsp_data_in.raw_x      = head_item.raw_x;
      rsp_data_in.raw_y      = head_item.raw_y;
      rsp_data_in.raw_z      = head_item.raw_z;
      rsp_data_in.scaled_x   = {prod_x[26:0], 1'b0};
      rsp_data_in.scaled_y   = {prod_y[26:0], 1'b0};
      rsp_data_in.scaled_z   = {prod_z[26:0], 1'b0};
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/imu_serial_frame_decoder.sv @@
// Channel  Direction  Beat
// req_     in         rx_byte, one received serial byte
// rsp_     out        frame_kind, raw_x/y/z, scaled_x/y/z of one decoded frame
// csr_     in/out     APB access to the three full-scale registers
//
// One byte is accepted every cycle while the queue is not full. A decoded frame
// enters the queue when its last byte is accepted, then passes through the axis
// multipliers into the output register once that register is free or being drained.
// Reset is synchronous and clears the frame position, queue and output valid.
// The two-entry queue absorbs output stalls; req_tready drops only when it is full.
module imu_serial_frame_decoder
   import imusfd_pkg::*;
#(
   parameter int FRAME_LENGTH = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,    // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] frame_kind, [17:2] raw_x, [33:18] raw_y, [49:34] raw_z,
   // [77:50] scaled_x, [105:78] scaled_y, [133:106] scaled_z, [135:134] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic           fifo_push;
   logic           fifo_pop;
   frame_item_type push_item;
   frame_item_type head_item;
   logic [1:0]     fifo_count;
   fs_cfg_type     cfg_ff;
   logic           csr_write;
   reg_index_type  csr_index;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_fs <= ACCEL_FS_RESET;
         cfg_ff.rate_fs  <= RATE_FS_RESET;
         cfg_ff.angle_fs <= ANGLE_FS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ACCEL_FS: cfg_ff.accel_fs <= csr_pwdata[4:0];
            REG_RATE_FS:  cfg_ff.rate_fs  <= csr_pwdata[10:0];
            REG_ANGLE_FS: cfg_ff.angle_fs <= csr_pwdata[7:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ACCEL_FS: csr_prdata = CSR_DATA_W'(cfg_ff.accel_fs);
         REG_RATE_FS:  csr_prdata = CSR_DATA_W'(cfg_ff.rate_fs);
         REG_ANGLE_FS: csr_prdata = CSR_DATA_W'(cfg_ff.angle_fs);
         default:      csr_prdata = '0;
      endcase
   end

   // Input side stalls only while the queue is full.
   assign req_tready = (fifo_count != QUEUE_DEPTH);

   imusfd_front #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (fifo_push),
      .push_item  (push_item)
   );

   imusfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_item (push_item),
      .pop       (fifo_pop),
      .head_item (head_item),
      .count     (fifo_count)
   );

   imusfd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .head_valid (fifo_count != 2'd0),
      .head_item  (head_item),
      .cfg        (cfg_ff),
      .pop        (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Queue never takes a frame while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_count != QUEUE_DEPTH))
      else $error("frame queue overflow");

   // Scaler never takes a frame from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> (fifo_count != 2'd0))
      else $error("frame queue underflow");

   // A lone push grows the queue by exactly one frame.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fifo_push && !fifo_pop) |=> (fifo_count == $past(fifo_count) + 2'd1))
      else $error("frame queue count mismatch");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import imusfd_pkg::*;
();

   localparam int FRAME_LEN       = 11;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 8;
   localparam int TAIL_CYCLES     = 16;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_BYTES     = 215;

   // Byte address of the first slot past the register map; writes there are dropped.
   localparam logic [CSR_ADDR_W-1:0] UNUSED_REG_ADDR = 4'hC;

   // One row of the directed table: optional junk bytes, then one complete frame.
   typedef struct {
      int         junk_count;
      logic [7:0] junk_byte;
      logic [7:0] type_byte;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic [7:0] tail_byte;
      bit         typed;       // expectation given below instead of the predictor
      bit         typed_hit;   // the frame gives a result
      kind_type   kind;
      int         sx;
      int         sy;
      int         sz;
   } frame_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: full-scale copies, frame position and stored frame bytes.
   logic [4:0]  accel_fs_model;
   logic [10:0] rate_fs_model;
   logic [7:0]  angle_fs_model;
   int          frame_pos;
   logic [7:0]  frame_store [STORED_BYTES];

   result_type  expected_frames [$];
   bit          typed_row_active;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int          fail_count;
   int          cycle_count;

   frame_row_type directed_rows [0:12] = '{
      '{0, 8'h00, TYPE_ACCEL, 16'h0000, 16'h0001, 16'hFFFF, 8'h00, 1, 1, KIND_ACCEL,
        0, 32, -32},
      '{0, 8'h00, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h00FF, 8'hFF, 1, 1, KIND_ACCEL,
        1048544, -1048576, 8160},
      '{0, 8'h00, TYPE_RATE, 16'h7FFF, 16'h8000, 16'h0001, 8'h55, 1, 1, KIND_RATE,
        131068000, -131072000, 4000},
      '{0, 8'h00, TYPE_ANGLE, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hAA, 1, 1, KIND_ANGLE,
        -360, 11796120, -11796480},
      '{3, 8'hFF, TYPE_ANGLE, 16'h1234, 16'hA5A5, 16'h5A5A, 8'h00, 0, 0, KIND_ACCEL,
        0, 0, 0},
      '{2, 8'h00, TYPE_RATE, 16'h5555, 16'hAAAA, 16'h0F0F, 8'h33, 0, 0, KIND_ACCEL,
        0, 0, 0},
      '{1, 8'h54, TYPE_ACCEL, 16'hF0F0, 16'h8001, 16'h7FFE, 8'hCC, 0, 0, KIND_ACCEL,
        0, 0, 0},
      '{0, 8'h00, 8'h50, 16'h7FFF, 16'h8000, 16'h0001, 8'h00, 1, 0, KIND_ACCEL,
        0, 0, 0},
      '{0, 8'h00, 8'h54, 16'h1111, 16'h2222, 16'h3333, 8'hFF, 1, 0, KIND_ACCEL,
        0, 0, 0},
      '{0, 8'h00, HEADER_BYTE, 16'h5555, 16'h5555, 16'h5555, 8'h55, 1, 0, KIND_ACCEL,
        0, 0, 0},
      '{0, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1, 0, KIND_ACCEL,
        0, 0, 0},
      '{0, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1, 0, KIND_ACCEL,
        0, 0, 0},
      '{0, 8'h00, TYPE_RATE, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1, 1, KIND_RATE,
        0, 0, 0}
   };

   imu_serial_frame_decoder #(
      .FRAME_LENGTH(FRAME_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Receiver back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input reg_index_type idx);
      return {idx, 2'b00};
   endfunction

   function automatic logic signed [27:0] scale_axis(input logic signed [15:0] raw,
                                                     input logic [10:0] fs);
      longint product;
      product = longint'(raw) * longint'(fs) * 2;
      return product[27:0];
   endfunction

   // Advances the frame collector by one byte; returns 1 when a known frame completes.
   function automatic bit decode_byte(input logic [7:0] b, output result_type r);
      logic [10:0]        fs;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic signed [15:0] rz;
      r = '0;
      if (frame_pos == 0) begin
         if (b == HEADER_BYTE) frame_pos = 1;
         return 1'b0;
      end
      // Bytes past the axis values are counted only.
      if (frame_pos <= STORED_BYTES) frame_store[frame_pos - 1] = b;
      frame_pos++;
      if (frame_pos < FRAME_LEN) return 1'b0;
      frame_pos = 0;
      case (frame_store[0])
         TYPE_ACCEL: begin
            r.frame_kind = KIND_ACCEL;
            fs = 11'(accel_fs_model);
         end
         TYPE_RATE: begin
            r.frame_kind = KIND_RATE;
            fs = rate_fs_model;
         end
         TYPE_ANGLE: begin
            r.frame_kind = KIND_ANGLE;
            fs = 11'(angle_fs_model);
         end
         default: return 1'b0;
      endcase
      rx = {frame_store[2], frame_store[1]};
      ry = {frame_store[4], frame_store[3]};
      rz = {frame_store[6], frame_store[5]};
      r.raw_x = rx;
      r.raw_y = ry;
      r.raw_z = rz;
      r.scaled_x = scale_axis(rx, fs);
      r.scaled_y = scale_axis(ry, fs);
      r.scaled_z = scale_axis(rz, fs);
      return 1'b1;
   endfunction

   function automatic void compare_field(input string name, input logic signed [63:0] want,
                                         input logic signed [63:0] seen);
      if (seen !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, seen);
         fail_count++;
      end
   endfunction

   // Output checking and prediction on accepted beats.
   always @(posedge clock) begin : scoreboard
      result_type seen;
      result_type want;
      result_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_frames.size() == 0) begin
               $error("result beat with no frame pending: frame_kind %0d raw_x %0d",
                      seen.frame_kind, seen.raw_x);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               compare_field("frame_kind", want.frame_kind, seen.frame_kind);
               compare_field("raw_x", want.raw_x, seen.raw_x);
               compare_field("raw_y", want.raw_y, seen.raw_y);
               compare_field("raw_z", want.raw_z, seen.raw_z);
               compare_field("scaled_x", want.scaled_x, seen.scaled_x);
               compare_field("scaled_y", want.scaled_y, seen.scaled_y);
               compare_field("scaled_z", want.scaled_z, seen.scaled_z);
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_byte(req_tdata, predicted) && !typed_row_active)
               expected_frames.push_back(predicted);
         end
      end
   end

   // Offers one byte, with random idle cycles first, and returns after its beat.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input logic [7:0] tail_byte, input bit random_tail);
      send_byte(HEADER_BYTE);
      send_byte(type_byte);
      send_byte(x[7:0]);
      send_byte(x[15:8]);
      send_byte(y[7:0]);
      send_byte(y[15:8]);
      send_byte(z[7:0]);
      send_byte(z[15:8]);
      for (int k = 8; k < FRAME_LEN; k++)
         send_byte(random_tail ? 8'($urandom) : tail_byte);
   endtask

   // Holds the sender off until every pending result has come out.
   task automatic wait_results_drained();
      req_tvalid = 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      // The register takes the value at this edge; only its low bits are kept.
      case (addr)
         reg_addr(REG_ACCEL_FS): accel_fs_model = value[4:0];
         reg_addr(REG_RATE_FS):  rate_fs_model  = value[10:0];
         reg_addr(REG_ANGLE_FS): angle_fs_model = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_read_check(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = reg_addr(idx);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_ACCEL_FS: want = CSR_DATA_W'(accel_fs_model);
         REG_RATE_FS:  want = CSR_DATA_W'(rate_fs_model);
         default:      want = CSR_DATA_W'(angle_fs_model);
      endcase
      if (csr_prdata !== want) begin
         $error("%s mismatch: expected %0d, got %0d", idx.name(), want, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic read_back_all();
      csr_read_check(REG_ACCEL_FS);
      csr_read_check(REG_RATE_FS);
      csr_read_check(REG_ANGLE_FS);
   endtask

   // Axis values lean toward the extremes and the sign boundary.
   function automatic logic [15:0] pick_axis_value();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames with random content, some junk bytes and unknown types.
   task automatic run_random_stream(input int byte_budget);
      int         sent;
      logic [7:0] type_byte;
      sent = 0;
      while (sent < byte_budget) begin
         if ($urandom_range(99) < 8) begin
            send_byte(8'($urandom));
            sent++;
         end else begin
            if ($urandom_range(99) < 85)
               type_byte = TYPE_ACCEL + 8'($urandom_range(2));
            else
               type_byte = 8'($urandom);
            send_frame(type_byte, pick_axis_value(), pick_axis_value(), pick_axis_value(),
                       8'h00, 1'b1);
            sent += FRAME_LEN;
         end
      end
   endtask

   initial begin : stimulus
      result_type  want;
      logic [31:0] accel_val;
      logic [31:0] rate_val;
      logic [31:0] angle_val;
      int          mode;

      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      typed_row_active = 1'b0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      fail_count       = 0;
      cycle_count      = 0;
      accel_fs_model   = ACCEL_FS_RESET;
      rate_fs_model    = RATE_FS_RESET;
      angle_fs_model   = ANGLE_FS_RESET;
      frame_pos        = 0;
      for (int i = 0; i < STORED_BYTES; i++) frame_store[i] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      read_back_all();

      // Directed frames, one at a time, each drained before the next.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            typed_row_active = 1'b1;
            if (directed_rows[i].typed_hit) begin
               want            = '0;
               want.frame_kind = directed_rows[i].kind;
               want.raw_x      = directed_rows[i].x;
               want.raw_y      = directed_rows[i].y;
               want.raw_z      = directed_rows[i].z;
               want.scaled_x   = directed_rows[i].sx[27:0];
               want.scaled_y   = directed_rows[i].sy[27:0];
               want.scaled_z   = directed_rows[i].sz[27:0];
               expected_frames.push_back(want);
            end
         end
         repeat (directed_rows[i].junk_count) send_byte(directed_rows[i].junk_byte);
         send_frame(directed_rows[i].type_byte, directed_rows[i].x, directed_rows[i].y,
                    directed_rows[i].z, directed_rows[i].tail_byte, 1'b0);
         typed_row_active = 1'b0;
         wait_results_drained();
      end

      // Random phases, each under its own full-scale setting and one of four idling patterns.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct = 0;
         stall_pct     = 0;
         wait_results_drained();
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
         case (phase)
            0: begin
               accel_val = 31;
               rate_val  = 2047;
               angle_val = 255;
            end
            1: begin
               accel_val = 0;
               rate_val  = 0;
               angle_val = 0;
            end
            2: begin
               accel_val = 1;
               rate_val  = 1;
               angle_val = 1;
            end
            3: begin
               accel_val = 16;
               rate_val  = 2000;
               angle_val = 180;
            end
            default: begin
               accel_val = $urandom;
               rate_val  = $urandom;
               angle_val = $urandom;
            end
         endcase
         // Random upper bits check that only the register width is kept.
         csr_write(reg_addr(REG_ACCEL_FS), ($urandom & ~32'h1F) | (accel_val & 32'h1F));
         csr_write(reg_addr(REG_RATE_FS), ($urandom & ~32'h7FF) | (rate_val & 32'h7FF));
         csr_write(reg_addr(REG_ANGLE_FS), ($urandom & ~32'hFF) | (angle_val & 32'hFF));
         if (phase == 5) csr_write(UNUSED_REG_ADDR, $urandom);
         read_back_all();

         mode = phase % 4;
         case (mode)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 69;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 69;
            end
            default: begin
               send_idle_pct = 10;
               stall_pct     = 10;
            end
         endcase
         run_random_stream(PHASE_BYTES);
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
